// ----- rtl/pis_pkg.sv -----
// Shared types, codes and defaults for the periodic identifier scheduler.
`timescale 1ns / 1ps
package pis_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int CFG_W     = 16;
  localparam int PER_W     = 16;

  localparam logic [7:0] EMPTY_ID = 8'hFF;

  localparam logic [1:0] OPC_TICK   = 2'd0;
  localparam logic [1:0] OPC_DEFINE = 2'd1;
  localparam logic [1:0] OPC_CLEAR  = 2'd2;

  localparam logic [7:0] MODE_SLOW = 8'd1;
  localparam logic [7:0] MODE_MED  = 8'd2;
  localparam logic [7:0] MODE_FAST = 8'd3;
  localparam logic [7:0] MODE_STOP = 8'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_MODE = 2'd1;
  localparam logic [1:0] ST_NO_SLOT  = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SEND   = 1'b1;

  localparam logic [1:0] REG_SLOW = 2'd0;
  localparam logic [1:0] REG_MED  = 2'd1;
  localparam logic [1:0] REG_FAST = 2'd2;

  localparam logic [PER_W-1:0] SLOW_RST = 16'd1000;
  localparam logic [PER_W-1:0] MED_RST  = 16'd200;
  localparam logic [PER_W-1:0] FAST_RST = 16'd50;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_DEFINE,
    CMD_CLEAR
  } cmd_op_t;

  typedef enum logic [2:0] {
    RATE_SLOW,
    RATE_MED,
    RATE_FAST,
    RATE_STOP,
    RATE_BAD
  } rate_t;

  typedef struct packed {
    cmd_op_t    op;
    rate_t      rate;
    logic [7:0] ident;
    logic [7:0] target;
  } cmd_t;

  typedef struct packed {
    logic [PER_W-1:0] slow_p;
    logic [PER_W-1:0] med_p;
    logic [PER_W-1:0] fast_p;
  } per_t;

endpackage

// ----- rtl/pis_ifs.sv -----
// Handshake channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface pis_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rate_mode;
  logic [7:0] ident;
  logic [7:0] target_addr;

  modport source (output valid, opcode, rate_mode, ident, target_addr, input ready);
  modport sink   (input valid, opcode, rate_mode, ident, target_addr, output ready);
endinterface

interface pis_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] status;
  logic [7:0] send_ident;
  logic [7:0] send_target;
  logic       last;

  modport source (output valid, kind, status, send_ident, send_target, last, input ready);
  modport sink   (input valid, kind, status, send_ident, send_target, last, output ready);
endinterface

// ----- rtl/periodic_identifier_scheduler.sv -----
// Top level of the periodic identifier scheduler: config registers, front and back.
//
// Input channel in_ch carries tick, define and clear transactions; result channel out_ch
// returns one status per define or clear and one send transaction per slot that falls due
// on a tick, in slot order, with last set on the final result of each input.
// cfg_we/cfg_idx/cfg_wdata write the slow, medium and fast periods (index 0..2).
// The front decodes each transaction into a two-entry command queue, so input is taken
// while the back is busy. The back walks the slot table one slot per clock, except while
// a tick's walk waits on a stalled receiver. The back takes a command from the queue only
// when idle and finishes it before it takes the next. A define or tick walks every slot
// before its final result, if any, is loaded; a clear loads its status without a walk.
// Earlier sends of a tick leave as soon as the next slot falls due. Opcode 3 is taken and dropped.
// Reset empties the table, loads the default periods (1000, 200, 50) and clears the
// queue and result register. A stalled receiver holds the result register; the walk
// pauses only when another result is ready to go, and the queue then fills and drops
// in_ch.ready.
`timescale 1ns / 1ps
module periodic_identifier_scheduler
  import pis_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  pis_in_if.sink           in_ch,
  pis_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  per_t per_r;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_r.slow_p <= SLOW_RST;
      per_r.med_p  <= MED_RST;
      per_r.fast_p <= FAST_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SLOW: per_r.slow_p <= cfg_wdata;
        REG_MED:  per_r.med_p  <= cfg_wdata;
        REG_FAST: per_r.fast_p <= cfg_wdata;
        default:  per_r        <= per_r;
      endcase
    end
  end

  pis_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  pis_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .per       (per_r),
    .out_ch    (out_ch)
  );

  a_send_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == KIND_SEND |-> out_ch.status == ST_OK)
    else $error("send transaction with nonzero status");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == KIND_STATUS |->
      out_ch.last && out_ch.send_ident == 8'd0 && out_ch.send_target == 8'd0)
    else $error("status transaction not final or carries slot data");

  a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid)
    else $error("back end took a command from an empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

// ----- rtl/pis_front.sv -----
// Front end: accepts input transactions, decodes them and queues commands.
`timescale 1ns / 1ps
module pis_front
  import pis_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  pis_in_if.sink in_ch,
  output logic   cmd_valid,
  output cmd_t   cmd,
  input  logic   cmd_take
);

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       dec;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready &&
                (in_ch.opcode == OPC_TICK || in_ch.opcode == OPC_DEFINE ||
                 in_ch.opcode == OPC_CLEAR);

  always_comb begin
    dec.ident  = in_ch.ident;
    dec.target = in_ch.target_addr;
    case (in_ch.opcode)
      OPC_DEFINE: dec.op = CMD_DEFINE;
      OPC_CLEAR:  dec.op = CMD_CLEAR;
      default:    dec.op = CMD_TICK;
    endcase
    case (in_ch.rate_mode)
      MODE_SLOW: dec.rate = RATE_SLOW;
      MODE_MED:  dec.rate = RATE_MED;
      MODE_FAST: dec.rate = RATE_FAST;
      MODE_STOP: dec.rate = RATE_STOP;
      default:   dec.rate = RATE_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (cmd_take) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_take);
    end
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

endmodule

// ----- rtl/pis_back.sv -----
// Back end: slot table, one-slot-per-cycle walker (paused by a stalled receiver) and result register.
`timescale 1ns / 1ps
module pis_back
  import pis_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  input  per_t      per,
  pis_out_if.source out_ch
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DEF,
    S_CLEAR
  } state_t;

  // slot table
  logic [SLOTS-1:0] occ_r;
  logic [7:0]       id_r  [SLOTS];
  logic [7:0]       tgt_r [SLOTS];
  logic [PER_W-1:0] rld_r [SLOTS];
  logic [PER_W-1:0] cd_r  [SLOTS];

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  cmd_t             cur_r, cur_nxt;
  logic             match_v_r, match_v_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic             free_v_r, free_v_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [7:0]       pend_id_r, pend_id_nxt;
  logic [7:0]       pend_tgt_r, pend_tgt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [7:0]       out_id_r, out_id_nxt;
  logic [7:0]       out_tgt_r, out_tgt_nxt;
  logic             out_last_r, out_last_nxt;

  // table write controls
  logic             wr_cd_en, wr_rld_en, wr_id_en, occ_set, occ_clr, occ_clr_all;
  logic [IDX_W-1:0] wr_idx;
  logic [PER_W-1:0] wr_cd, wr_rld;

  logic [IDX_W-1:0] k;
  logic             at_end, can_load, run, fire;
  logic [PER_W-1:0] cd_k, period;

  assign k        = k_r[IDX_W-1:0];
  assign at_end   = (k_r == CNT_W'(SLOTS));
  assign can_load = !out_valid_r || out_ch.ready;
  assign cd_k     = cd_r[k];
  assign run      = occ_r[k] && (cd_k != '0);
  assign fire     = run && (cd_k == PER_W'(1));
  assign cmd_take = (state_r == S_IDLE) && cmd_valid;

  always_comb begin
    case (cur_r.rate)
      RATE_SLOW: period = per.slow_p;
      RATE_MED:  period = per.med_p;
      RATE_FAST: period = per.fast_p;
      default:   period = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    cur_nxt        = cur_r;
    match_v_nxt    = match_v_r;
    match_idx_nxt  = match_idx_r;
    free_v_nxt     = free_v_r;
    free_idx_nxt   = free_idx_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    pend_tgt_nxt   = pend_tgt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_tgt_nxt    = out_tgt_r;
    out_last_nxt   = out_last_r;
    wr_cd_en       = 1'b0;
    wr_rld_en      = 1'b0;
    wr_id_en       = 1'b0;
    occ_set        = 1'b0;
    occ_clr        = 1'b0;
    occ_clr_all    = 1'b0;
    wr_idx         = k;
    wr_cd          = cd_k - PER_W'(1);
    wr_rld         = period;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cur_nxt     = cmd;
          k_nxt       = '0;
          match_v_nxt = 1'b0;
          free_v_nxt  = 1'b0;
          pend_v_nxt  = 1'b0;
          case (cmd.op)
            CMD_TICK:   state_nxt = S_TICK;
            CMD_DEFINE: state_nxt = S_DEF;
            default:    state_nxt = S_CLEAR;
          endcase
        end
      end
      S_CLEAR: begin
        if (can_load) begin
          occ_clr_all    = 1'b1;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_STATUS;
          out_status_nxt = ST_OK;
          out_id_nxt     = '0;
          out_tgt_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_TICK: begin
        if (!at_end) begin
          if (!(fire && pend_v_r && !can_load)) begin
            k_nxt = k_r + CNT_W'(1);
            if (run) begin
              wr_cd_en = 1'b1;
              if (fire) begin
                wr_cd = rld_r[k];
              end
            end
            if (fire) begin
              if (pend_v_r) begin
                out_valid_nxt  = 1'b1;
                out_kind_nxt   = KIND_SEND;
                out_status_nxt = ST_OK;
                out_id_nxt     = pend_id_r;
                out_tgt_nxt    = pend_tgt_r;
                out_last_nxt   = 1'b0;
              end
              pend_v_nxt   = 1'b1;
              pend_id_nxt  = id_r[k];
              pend_tgt_nxt = tgt_r[k];
            end
          end
        end else if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_SEND;
          out_status_nxt = ST_OK;
          out_id_nxt     = pend_id_r;
          out_tgt_nxt    = pend_tgt_r;
          out_last_nxt   = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_DEF: begin
        if (!at_end) begin
          k_nxt = k_r + CNT_W'(1);
          if (occ_r[k] && id_r[k] == cur_r.ident && !match_v_r) begin
            match_v_nxt   = 1'b1;
            match_idx_nxt = k;
          end
          if (!occ_r[k] && !free_v_r) begin
            free_v_nxt   = 1'b1;
            free_idx_nxt = k;
          end
        end else if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_STATUS;
          out_status_nxt = ST_OK;
          out_id_nxt     = '0;
          out_tgt_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
          wr_cd          = period;
          if (cur_r.rate == RATE_BAD) begin
            out_status_nxt = ST_BAD_MODE;
          end else if (cur_r.ident == EMPTY_ID) begin
            out_status_nxt = ST_OK;
          end else if (match_v_r) begin
            wr_idx    = match_idx_r;
            wr_cd_en  = 1'b1;
            wr_rld_en = 1'b1;
            occ_clr   = (cur_r.rate == RATE_STOP);
          end else if (cur_r.rate == RATE_STOP) begin
            out_status_nxt = ST_OK;
          end else if (free_v_r) begin
            wr_idx    = free_idx_r;
            wr_cd_en  = 1'b1;
            wr_rld_en = 1'b1;
            wr_id_en  = 1'b1;
            occ_set   = 1'b1;
          end else begin
            out_status_nxt = ST_NO_SLOT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (occ_clr_all) begin
      occ_r <= '0;
    end else if (occ_set) begin
      occ_r[wr_idx] <= 1'b1;
    end else if (occ_clr) begin
      occ_r[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cd_en) begin
      cd_r[wr_idx] <= wr_cd;
    end
    if (wr_rld_en) begin
      rld_r[wr_idx] <= wr_rld;
    end
    if (wr_id_en) begin
      id_r[wr_idx]  <= cur_r.ident;
      tgt_r[wr_idx] <= cur_r.target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r          <= k_nxt;
    cur_r        <= cur_nxt;
    match_v_r    <= match_v_nxt;
    match_idx_r  <= match_idx_nxt;
    free_v_r     <= free_v_nxt;
    free_idx_r   <= free_idx_nxt;
    pend_id_r    <= pend_id_nxt;
    pend_tgt_r   <= pend_tgt_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_tgt_r    <= out_tgt_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.send_ident  = out_id_r;
  assign out_ch.send_target = out_tgt_r;
  assign out_ch.last        = out_last_r;

endmodule
